// ----- hw/rtl/psched_pkg.sv -----
// psched_pkg: shared constants, opcodes, status codes, types and helper functions for the
// preemptive priority scheduler. No dependencies.
package psched_pkg;

	localparam int MAX_PROC = 16;
	localparam int SLOT_W   = (MAX_PROC > 1) ? $clog2(MAX_PROC) : 1;
	localparam int CNT_W    = $clog2(MAX_PROC + 1);
	localparam int NUM_W    = 5;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_REPORT = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;

	localparam logic [15:0] SAT16 = 16'hFFFF;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef struct packed {
		logic [7:0]  arrival;
		logic [7:0]  burst;
		logic [7:0]  remaining;
		logic [3:0]  prio;
		logic [15:0] waiting;
	} entry_t;

	typedef struct packed {
		logic   we;
		slot_t  waddr;
		entry_t wdata;
		logic   re;
		slot_t  raddr;
	} mem_req_t;

	// one-based process number, masked to the field width
	function automatic logic [NUM_W-1:0] slot_num(input slot_t s);
		int n;
		n = int'(s) + 1;
		return n[NUM_W-1:0];
	endfunction

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == SAT16) ? v : v + 16'd1;
	endfunction

endpackage

// ----- hw/rtl/psched_in_if.sv -----
// psched_in_if: command word channel (valid/ready plus payload).
// No dependencies.
interface psched_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] arrival_time;
	logic [7:0] burst_time;
	logic [3:0] priority_req;

	modport source(output valid, output opcode, output arrival_time,
		output burst_time, output priority_req, input ready);
	modport sink(input valid, input opcode, input arrival_time,
		input burst_time, input priority_req, output ready);
endinterface

// ----- hw/rtl/psched_out_if.sv -----
// psched_out_if: result word channel (valid/ready plus payload).
// No dependencies.
interface psched_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [4:0]  process_number;
	logic [15:0] waiting_time;
	logic [15:0] turnaround_time;
	logic [15:0] current_time;
	logic        last;

	modport source(output valid, output status, output process_number,
		output waiting_time, output turnaround_time, output current_time,
		output last, input ready);
	modport sink(input valid, input status, input process_number,
		input waiting_time, input turnaround_time, input current_time,
		input last, output ready);
endinterface

// ----- hw/rtl/psched_ram.sv -----
// psched_ram: process table, one write port and one registered read port.
// Depends on psched_pkg.
module psched_ram (
	input  logic                clk,
	input  psched_pkg::mem_req_t req,
	output psched_pkg::entry_t   rdata
);

	psched_pkg::entry_t mem_q [psched_pkg::MAX_PROC];
	psched_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/psched_ctrl.sv -----
// psched_ctrl: opcode sequencer, table scan with read-modify-write of the
// table memory, and the result output register. Depends on psched_pkg,
// psched_in_if, psched_out_if.
module psched_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	psched_in_if.sink            cmd,
	psched_out_if.source         rsp,
	output psched_pkg::mem_req_t mem_req,
	input  psched_pkg::entry_t   mem_rdata
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PUSH  = 3'd1;
	localparam logic [2:0] S_TSCAN = 3'd2;
	localparam logic [2:0] S_TFIN  = 3'd3;
	localparam logic [2:0] S_RRD   = 3'd4;
	localparam logic [2:0] S_RWT   = 3'd5;

	logic [2:0]              state_q;
	psched_pkg::cnt_t        count_q;
	logic [15:0]             time_q;
	psched_pkg::slot_t       idx_q;
	logic                    win_vld_q;
	psched_pkg::slot_t       win_idx_q;
	psched_pkg::entry_t      win_q;
	logic [1:0]              res_status_q;
	logic [4:0]              res_num_q;

	logic                    out_vld_q;
	logic [1:0]              out_status_q;
	logic [4:0]              out_num_q;
	logic [15:0]             out_wait_q;
	logic [15:0]             out_tat_q;
	logic [15:0]             out_time_q;
	logic                    out_last_q;

	logic                    accept;
	logic                    can_push;
	logic                    push_out;
	logic                    is_last;
	logic                    has_room;
	logic                    rd_ready;
	logic                    better;
	logic [15:0]             time_next;
	logic [16:0]             tat_sum;
	logic [15:0]             tat_sat;
	psched_pkg::entry_t      scan_wb;
	psched_pkg::entry_t      win_wb;
	psched_pkg::entry_t      load_wd;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign can_push  = !out_vld_q || rsp.ready;
	assign push_out  = ((state_q == S_PUSH) || (state_q == S_RWT)) && can_push;
	assign is_last   = (psched_pkg::cnt_t'(idx_q) + psched_pkg::cnt_t'(1)) == count_q;
	assign has_room  = count_q < psched_pkg::cnt_t'(psched_pkg::MAX_PROC);

	assign rd_ready = ({8'd0, mem_rdata.arrival} <= time_q) && (mem_rdata.remaining != 8'd0);
	assign better   = !win_vld_q || (mem_rdata.prio > win_q.prio) ||
		((mem_rdata.prio == win_q.prio) && (mem_rdata.arrival < win_q.arrival));

	assign time_next = psched_pkg::sat_inc16(time_q);
	assign tat_sum   = {1'b0, mem_rdata.waiting} + {9'd0, mem_rdata.burst};
	assign tat_sat   = tat_sum[16] ? psched_pkg::SAT16 : tat_sum[15:0];

	always_comb begin
		scan_wb         = mem_rdata;
		scan_wb.waiting = psched_pkg::sat_inc16(mem_rdata.waiting);
		win_wb           = win_q;
		win_wb.remaining = win_q.remaining - 8'd1;
		load_wd.arrival   = cmd.arrival_time;
		load_wd.burst     = cmd.burst_time;
		load_wd.remaining = cmd.burst_time;
		load_wd.prio      = cmd.priority_req;
		load_wd.waiting   = 16'd0;
	end

	// memory requests
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd.opcode == psched_pkg::OP_LOAD && has_room) begin
						mem_req.we    = 1'b1;
						mem_req.waddr = psched_pkg::slot_t'(count_q);
						mem_req.wdata = load_wd;
					end else if ((cmd.opcode == psched_pkg::OP_TICK ||
						cmd.opcode == psched_pkg::OP_REPORT) && count_q != '0) begin
						mem_req.re = 1'b1;
					end
				end
			end
			S_TSCAN: begin
				if (rd_ready) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = idx_q;
					mem_req.wdata = scan_wb;
				end
				if (!is_last) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = idx_q + psched_pkg::slot_t'(1);
				end
			end
			S_TFIN: begin
				if (win_vld_q) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = win_idx_q;
					mem_req.wdata = win_wb;
				end
			end
			S_RRD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = idx_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			time_q       <= '0;
			idx_q        <= '0;
			win_vld_q    <= 1'b0;
			win_idx_q    <= '0;
			win_q        <= '0;
			res_status_q <= psched_pkg::ST_OK;
			res_num_q    <= '0;
			out_vld_q    <= 1'b0;
			out_status_q <= psched_pkg::ST_OK;
			out_num_q    <= '0;
			out_wait_q   <= '0;
			out_tat_q    <= '0;
			out_time_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (push_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (cmd.opcode)
							psched_pkg::OP_LOAD: begin
								if (has_room) begin
									count_q      <= count_q + psched_pkg::cnt_t'(1);
									res_status_q <= psched_pkg::ST_OK;
									res_num_q    <= psched_pkg::slot_num(
										psched_pkg::slot_t'(count_q));
								end else begin
									res_status_q <= psched_pkg::ST_FULL;
									res_num_q    <= '0;
								end
								state_q <= S_PUSH;
							end
							psched_pkg::OP_TICK: begin
								if (count_q == '0) begin
									time_q       <= time_next;
									res_status_q <= psched_pkg::ST_NONE;
									res_num_q    <= '0;
									state_q      <= S_PUSH;
								end else begin
									idx_q     <= '0;
									win_vld_q <= 1'b0;
									state_q   <= S_TSCAN;
								end
							end
							psched_pkg::OP_REPORT: begin
								if (count_q == '0) begin
									res_status_q <= psched_pkg::ST_OK;
									res_num_q    <= '0;
									state_q      <= S_PUSH;
								end else begin
									idx_q   <= '0;
									state_q <= S_RWT;
								end
							end
							psched_pkg::OP_CLEAR: begin
								count_q      <= '0;
								time_q       <= '0;
								res_status_q <= psched_pkg::ST_OK;
								res_num_q    <= '0;
								state_q      <= S_PUSH;
							end
						endcase
					end
				end
				S_TSCAN: begin
					if (rd_ready && better) begin
						win_vld_q <= 1'b1;
						win_idx_q <= idx_q;
						win_q     <= mem_rdata;
					end
					if (is_last) begin
						state_q <= S_TFIN;
					end else begin
						idx_q <= idx_q + psched_pkg::slot_t'(1);
					end
				end
				S_TFIN: begin
					time_q       <= time_next;
					res_status_q <= win_vld_q ? psched_pkg::ST_OK : psched_pkg::ST_NONE;
					res_num_q    <= win_vld_q ? psched_pkg::slot_num(win_idx_q) : 5'd0;
					state_q      <= S_PUSH;
				end
				S_PUSH: begin
					if (can_push) begin
						out_status_q <= res_status_q;
						out_num_q    <= res_num_q;
						out_wait_q   <= '0;
						out_tat_q    <= '0;
						out_time_q   <= time_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_RRD: begin
					state_q <= S_RWT;
				end
				S_RWT: begin
					if (can_push) begin
						out_status_q <= psched_pkg::ST_OK;
						out_num_q    <= psched_pkg::slot_num(idx_q);
						out_wait_q   <= mem_rdata.waiting;
						out_tat_q    <= tat_sat;
						out_time_q   <= time_q;
						out_last_q   <= is_last;
						if (is_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + psched_pkg::slot_t'(1);
							state_q <= S_RRD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.status          = out_status_q;
	assign rsp.process_number  = out_num_q;
	assign rsp.waiting_time    = out_wait_q;
	assign rsp.turnaround_time = out_tat_q;
	assign rsp.current_time    = out_time_q;
	assign rsp.last            = out_last_q;

endmodule

// ----- hw/rtl/preemptive_priority_scheduler_top.sv -----
// preemptive_priority_scheduler_top: process table plus sequencer.
// Depends on psched_pkg, psched_in_if, psched_out_if, psched_ram, psched_ctrl.
//
//   channel | dir | word
//   --------+-----+-----------------------------------------------------------
//   cmd     | in  | opcode, arrival_time, burst_time, priority_req
//   rsp     | out | status, process_number, waiting_time, turnaround_time,
//           |     | current_time, last
//
// Sequence: load, clear and a tick on an empty table go from the accept straight
//   to posting the result; a tick on loaded processes takes the accept, one table
//   entry per cycle through the memory read port, the winner write-back, then
//   posts the result; a report reads each row through the registered read port
//   of the table and posts it before it reads the next row.
// Reset: asynchronous; count and time go to zero, no clearing pass.
// Stalls: results sit in an output register; a new command word is taken once
//   the previous result has moved there, even if rsp is still stalled.
module preemptive_priority_scheduler_top (
	input  logic         clk,
	input  logic         arst_n,
	psched_in_if.sink    cmd,
	psched_out_if.source rsp
);

	// table access from the sequencer: one write and one read per cycle
	psched_pkg::mem_req_t mem_req;
	psched_pkg::entry_t   mem_rdata;

	psched_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// scan does read-ahead of entry i+1 while writing back entry i
	psched_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rsp       (rsp),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	// read-ahead and write-back never hit the same entry in one cycle
	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
		else $error("table read and write to the same entry");

	// error results are single-word and carry no process number
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != psched_pkg::ST_OK) |->
		(rsp.last && rsp.process_number == 5'd0))
		else $error("error result malformed");

	// turnaround always covers the waiting time
	a_tat_ge_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.turnaround_time >= rsp.waiting_time))
		else $error("turnaround below waiting time");

	// a command is never taken in the same cycle as a table scan write-back
	a_idle_take: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && mem_req.we) |->
		(cmd.opcode == psched_pkg::OP_LOAD))
		else $error("table written outside a load while taking a command");

endmodule
